>>> src/svn_pkg.sv
// ----------------------------------------------------------------------------
// svn_pkg: shared types and constants for the sparse voxel neighbor test
// Opcodes, field widths, the neighbor offset table and the control/status
// bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package svn_pkg;

  localparam int COORD_W      = 21;
  localparam int COUNT_W      = 13;
  localparam int DEF_CAPACITY = 4096;
  localparam int DEF_AXIS     = 21;
  localparam int NB_TOTAL     = 27;
  localparam int NB_W         = 5;
  localparam int NB_CENTER    = 13;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 16;

  typedef logic [1:0] op_t;
  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

  // neighbor n = 9*(dx+1) + 3*(dy+1) + (dz+1)
  typedef logic signed [1:0] off_t;

  function automatic off_t nb_off(input logic [1:0] digit);
    off_t o;
    case (digit)
      2'd0:    o = -2'sd1;
      2'd1:    o = 2'sd0;
      default: o = 2'sd1;
    endcase
    return o;
  endfunction

  typedef struct packed {
    logic load;
    logic clr_step;
    logic cnt_clear;
    logic probe_self;
    logic probe_nb;
    logic rd_issue;
    logic probe_adv;
    logic set_present;
    logic set_missing;
    logic set_full;
    logic ins_write;
    logic nb_adv;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
    logic empty;
    logic exhaust;
    logic is_full;
    logic nb_end;
    logic nb_skip;
    logic nb_oob;
    op_t  op;
  } status_t;

endpackage
`default_nettype wire

>>> src/svn_dp.sv
// ----------------------------------------------------------------------------
// svn_dp: voxel set datapath
// Hashed key memory with linear probing, probe registers, neighbor key
// generation, clear sweep and result flags.
// ----------------------------------------------------------------------------
`default_nettype none
module svn_dp #(
  parameter int SET_CAPACITY = svn_pkg::DEF_CAPACITY,
  parameter int AXIS_BITS    = svn_pkg::DEF_AXIS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  svn_pkg::cmd_t                 cmd,
  output svn_pkg::status_t              status,
  input  wire [1:0]                     in_op,
  input  wire [svn_pkg::COORD_W-1:0]    in_x,
  input  wire [svn_pkg::COORD_W-1:0]    in_y,
  input  wire [svn_pkg::COORD_W-1:0]    in_z,
  input  wire                           mode_full,
  output logic                          res_missing,
  output logic                          res_present,
  output logic                          res_full,
  output logic [svn_pkg::COUNT_W-1:0]   res_count
);
  import svn_pkg::*;

  localparam int KEY_W = 3 * AXIS_BITS;
  localparam int IDX_W = $clog2(SET_CAPACITY);
  localparam int CNT_W = $clog2(SET_CAPACITY + 1);

  logic [KEY_W:0]               mem [SET_CAPACITY];
  logic [KEY_W:0]               rd_q;
  op_t                          op_r;
  logic signed [AXIS_BITS-1:0]  x_r, y_r, z_r;
  logic [NB_W-1:0]              nb_r;
  logic [KEY_W-1:0]             key_r;
  logic [IDX_W-1:0]             idx_r, clr_idx_r;
  logic [CNT_W-1:0]             pcnt_r, count_r;
  logic                         missing_r, present_r, full_r;

  function automatic logic [IDX_W-1:0] hash_idx(input logic [KEY_W-1:0] k);
    logic [IDX_W-1:0] h;
    logic [IDX_W:0]   hw;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ k[i];
    end
    hw = {1'b0, h};
    if (hw >= (IDX_W+1)'(SET_CAPACITY)) begin
      hw = hw - (IDX_W+1)'(SET_CAPACITY);
    end
    return hw[IDX_W-1:0];
  endfunction

  function automatic logic [AXIS_BITS-1:0] axis_key(input logic [AXIS_BITS-1:0] v);
    return {~v[AXIS_BITS-1], v[AXIS_BITS-2:0]};
  endfunction

  // neighbor coordinates, one bit wider to catch range overflow
  logic [NB_W-1:0]              nb_sel, nb_tmp;
  logic [1:0]                   dgx, dgy, dgz;
  off_t                         dx, dy, dz;
  logic signed [AXIS_BITS:0]    nx, ny, nz;
  logic [1:0]                   manh;
  logic [KEY_W-1:0]             self_key, nb_key;

  always_comb begin
    nb_sel = (nb_r == NB_W'(NB_TOTAL)) ? '0 : nb_r;
    // split the neighbor index into base-3 digits by compare and subtract
    dgx    = (nb_sel >= NB_W'(18)) ? 2'd2 : (nb_sel >= NB_W'(9)) ? 2'd1 : 2'd0;
    nb_tmp = nb_sel - NB_W'(dgx) * NB_W'(9);
    dgy    = (nb_tmp >= NB_W'(6)) ? 2'd2 : (nb_tmp >= NB_W'(3)) ? 2'd1 : 2'd0;
    dgz    = 2'(nb_tmp - NB_W'(dgy) * NB_W'(3));
    dx     = nb_off(dgx);
    dy     = nb_off(dgy);
    dz     = nb_off(dgz);
    nx     = (AXIS_BITS+1)'(x_r) + (AXIS_BITS+1)'(dx);
    ny     = (AXIS_BITS+1)'(y_r) + (AXIS_BITS+1)'(dy);
    nz     = (AXIS_BITS+1)'(z_r) + (AXIS_BITS+1)'(dz);
    manh   = 2'(dgx != 2'd1) + 2'(dgy != 2'd1) + 2'(dgz != 2'd1);
    self_key = {axis_key(x_r), axis_key(y_r), axis_key(z_r)};
    nb_key   = {axis_key(nx[AXIS_BITS-1:0]), axis_key(ny[AXIS_BITS-1:0]),
                axis_key(nz[AXIS_BITS-1:0])};
  end

  always_comb begin
    status.clr_last = (clr_idx_r == IDX_W'(SET_CAPACITY - 1));
    status.hit      = rd_q[KEY_W] && (rd_q[KEY_W-1:0] == key_r);
    status.empty    = !rd_q[KEY_W];
    status.exhaust  = (pcnt_r == CNT_W'(SET_CAPACITY - 1));
    status.is_full  = (count_r >= CNT_W'(SET_CAPACITY));
    status.nb_end   = (nb_r == NB_W'(NB_TOTAL));
    status.nb_skip  = (manh == 2'd0) || (!mode_full && manh != 2'd1);
    status.nb_oob   = (nx[AXIS_BITS] != nx[AXIS_BITS-1]) ||
                      (ny[AXIS_BITS] != ny[AXIS_BITS-1]) ||
                      (nz[AXIS_BITS] != nz[AXIS_BITS-1]);
    status.op       = op_r;
  end

  // key memory: one write port (clear sweep or insert), one read port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_idx_r] <= '0;
    end else if (cmd.ins_write) begin
      mem[idx_r] <= {1'b1, key_r};
    end
    if (cmd.rd_issue) begin
      rd_q <= mem[idx_r];
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      x_r  <= in_x[AXIS_BITS-1:0];
      y_r  <= in_y[AXIS_BITS-1:0];
      z_r  <= in_z[AXIS_BITS-1:0];
    end
    if (cmd.probe_self) begin
      key_r <= self_key;
      idx_r <= hash_idx(self_key);
    end else if (cmd.probe_nb) begin
      key_r <= nb_key;
      idx_r <= hash_idx(nb_key);
    end else if (cmd.probe_adv) begin
      idx_r <= (idx_r == IDX_W'(SET_CAPACITY - 1)) ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      count_r   <= '0;
      pcnt_r    <= '0;
      nb_r      <= '0;
      missing_r <= 1'b0;
      present_r <= 1'b0;
      full_r    <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx_r <= status.clr_last ? '0 : clr_idx_r + 1'b1;
      end
      if (cmd.cnt_clear) begin
        count_r <= '0;
      end else if (cmd.ins_write) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.probe_self || cmd.probe_nb) begin
        pcnt_r <= '0;
      end else if (cmd.probe_adv) begin
        pcnt_r <= pcnt_r + 1'b1;
      end
      if (cmd.load) begin
        nb_r      <= '0;
        missing_r <= 1'b0;
        present_r <= 1'b0;
        full_r    <= 1'b0;
      end else begin
        if (cmd.nb_adv)      nb_r      <= nb_r + 1'b1;
        if (cmd.set_missing) missing_r <= 1'b1;
        if (cmd.set_present) present_r <= 1'b1;
        if (cmd.set_full)    full_r    <= 1'b1;
      end
    end
  end

  logic [CNT_W+COUNT_W-1:0] count_wide;
  assign count_wide  = (CNT_W+COUNT_W)'(count_r);
  assign res_count   = count_wide[COUNT_W-1:0];
  assign res_missing = missing_r;
  assign res_present = present_r;
  assign res_full    = full_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SET_CAPACITY))
    else $error("voxel count above capacity");
  a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_write |-> (status.empty && !status.is_full))
    else $error("insert into occupied slot or full set");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_write |=> count_r == $past(count_r) + 1'b1)
    else $error("count did not advance on insert");
`endif

endmodule
`default_nettype wire

>>> src/svn_ctrl.sv
// ----------------------------------------------------------------------------
// svn_ctrl: item sequencer
// Walks clear sweeps, self lookup, insert and the neighbor probe loop.
// ----------------------------------------------------------------------------
`default_nettype none
module svn_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire [1:0]         in_op,
  output logic              in_ready,
  input  wire               out_free,
  output logic              out_load,
  input  svn_pkg::status_t  status,
  output svn_pkg::cmd_t     cmd
);
  import svn_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_START = 7'b0000100,
    S_RD    = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_NB    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   from_item_r, from_item_nxt;
  logic   self_r, self_nxt;
  logic   miss;

  assign in_ready = (state_r == S_IDLE);
  assign miss     = status.empty || (!status.hit && status.exhaust);

  always_comb begin
    state_nxt     = state_r;
    from_item_nxt = from_item_r;
    self_nxt      = self_r;
    cmd           = '0;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == OP_CLEAR) begin
            from_item_nxt = 1'b1;
            state_nxt     = S_CLEAR;
          end else if (in_op == OP_INSERT || in_op == OP_QUERY) begin
            state_nxt = S_START;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          cmd.cnt_clear = 1'b1;
          state_nxt     = from_item_r ? S_DONE : S_IDLE;
        end
      end
      S_START: begin
        cmd.probe_self = 1'b1;
        self_nxt       = 1'b1;
        state_nxt      = S_RD;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        if (status.hit || miss) begin
          if (self_r) begin
            cmd.set_present = status.hit;
            if (status.op == OP_INSERT) begin
              if (!status.hit) begin
                if (status.is_full) cmd.set_full  = 1'b1;
                else                cmd.ins_write = 1'b1;
              end
              state_nxt = S_DONE;
            end else begin
              self_nxt  = 1'b0;
              state_nxt = S_NB;
            end
          end else if (status.hit) begin
            cmd.nb_adv = 1'b1;
            state_nxt  = S_NB;
          end else begin
            cmd.set_missing = 1'b1;
            state_nxt       = S_DONE;
          end
        end else begin
          // occupied by another key: step to the next slot
          cmd.probe_adv = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_NB: begin
        if (status.nb_end) begin
          state_nxt = S_DONE;
        end else if (status.nb_skip) begin
          cmd.nb_adv = 1'b1;
        end else if (status.nb_oob) begin
          cmd.set_missing = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.probe_nb = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      from_item_r <= 1'b0;
      self_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      from_item_r <= (state_r == S_IDLE) ? from_item_nxt && in_valid : from_item_nxt;
      self_r      <= self_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state not one-hot");
  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && status.clr_last) |=> state_r != S_CLEAR)
    else $error("clear sweep did not end");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE)
    else $error("item loaded while busy");
`endif

endmodule
`default_nettype wire

>>> src/sparse_voxel_neighbor_test.sv
// ----------------------------------------------------------------------------
// sparse_voxel_neighbor_test: voxel set with neighbor boundary test
// One item in work at a time; a missing neighbor ends a query early. The next item
// is accepted the cycle after the result is loaded. After reset a clear sweep over
// the whole key memory runs before the first item.
// ----------------------------------------------------------------------------
`default_nettype none
module sparse_voxel_neighbor_test #(
  parameter int SET_CAPACITY = svn_pkg::DEF_CAPACITY,
  parameter int AXIS_BITS    = svn_pkg::DEF_AXIS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire                              cfg_wr_data,    // full_connectivity
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [svn_pkg::IN_DATA_W-1:0]     in_tdata,       // coord_x, coord_y, coord_z
  input  wire [1:0]                        in_tuser,       // op
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [svn_pkg::OUT_DATA_W-1:0]   out_tdata       // neighbor_missing,
                                                           // self_present, set_full,
                                                           // voxel_count
);
  import svn_pkg::*;

  cmd_t                 cmd;
  status_t              status;
  logic                 mode_full_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 out_load, out_free;
  logic                 res_missing, res_present, res_full;
  logic [COUNT_W-1:0]   res_count;

  assign out_free = !out_valid_r || out_tready;

  svn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .out_free (out_free),
    .out_load (out_load),
    .status   (status),
    .cmd      (cmd)
  );

  svn_dp #(
    .SET_CAPACITY (SET_CAPACITY),
    .AXIS_BITS    (AXIS_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_op       (in_tuser),
    .in_x        (in_tdata[COORD_W-1:0]),
    .in_y        (in_tdata[2*COORD_W-1:COORD_W]),
    .in_z        (in_tdata[3*COORD_W-1:2*COORD_W]),
    .mode_full   (mode_full_r),
    .res_missing (res_missing),
    .res_present (res_present),
    .res_full    (res_full),
    .res_count   (res_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_full_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_full_r <= cfg_wr_data;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_DATA_W'({res_count, res_full, res_present, res_missing});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the sparse voxel neighbor test block
// Directed and random insert/query/clear items in face and full connectivity
// modes, a dense cube fill, random idle gaps on both streams and a long
// receiver hold. Every result is checked against a behavioral voxel set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import svn_pkg::*;

  localparam op_t OP_NOP   = 2'd3;
  localparam int  CAP      = 4096;
  localparam int  AXIS_MIN = -1048576;
  localparam int  AXIS_MAX = 1048575;
  localparam int  WD_LIMIT = 400000;

  typedef struct packed {
    logic [12:0] voxel_count;
    logic        set_full;
    logic        self_present;
    logic        neighbor_missing;
  } voxel_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // voxel set as the block should hold it
  bit            occupied[bit [62:0]];
  int            occ_count;
  bit            full_conn;
  voxel_result_t pending_results[$];
  bit            failed;
  bit            hold_receiver;
  bit            quiet;
  int            idle_cycles;

  sparse_voxel_neighbor_test dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit voxel_held(longint x, longint y, longint z);
    bit [20:0] bx, by, bz;
    bx = x[20:0];
    by = y[20:0];
    bz = z[20:0];
    return occupied.exists({bx, by, bz});
  endfunction

  function automatic voxel_result_t apply_voxel_op(op_t op, logic signed [20:0] x,
                                                   logic signed [20:0] y,
                                                   logic signed [20:0] z);
    voxel_result_t r;
    longint nx, ny, nz;
    int hops;
    r = '0;
    case (op)
      OP_CLEAR: begin
        occupied.delete();
        occ_count = 0;
      end
      OP_INSERT: begin
        if (occupied.exists({x, y, z})) r.self_present = 1'b1;
        else if (occ_count >= CAP) r.set_full = 1'b1;
        else begin
          occupied[{x, y, z}] = 1'b1;
          occ_count++;
        end
      end
      OP_QUERY: begin
        r.self_present = occupied.exists({x, y, z}) ? 1'b1 : 1'b0;
        for (int dx = -1; dx <= 1; dx++)
          for (int dy = -1; dy <= 1; dy++)
            for (int dz = -1; dz <= 1; dz++) begin
              hops = (dx != 0) + (dy != 0) + (dz != 0);
              nx = longint'(x) + dx;
              ny = longint'(y) + dy;
              nz = longint'(z) + dz;
              if (hops != 0 && (full_conn || hops == 1)) begin
                if (nx < AXIS_MIN || nx > AXIS_MAX || ny < AXIS_MIN || ny > AXIS_MAX ||
                    nz < AXIS_MIN || nz > AXIS_MAX)
                  r.neighbor_missing = 1'b1;
                else if (!voxel_held(nx, ny, nz))
                  r.neighbor_missing = 1'b1;
              end
            end
      end
      default: ;
    endcase
    r.voxel_count = occ_count[12:0];
    return r;
  endfunction

  task automatic send_voxel(op_t op, int x, int y, int z);
    int gap;
    logic signed [20:0] sx, sy, sz;
    voxel_result_t res;
    gap = quiet ? 0 : $urandom_range(0, 10);
    sx = x[20:0];
    sy = y[20:0];
    sz = z[20:0];
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, sz, sy, sx};
    do @(posedge clk); while (!in_tready);
    res = apply_voxel_op(op, sx, sy, sz);
    pending_results = {pending_results, res};
  endtask

  // stop offering and let every result drain before touching the register
  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_connectivity(bit v);
    drain_results();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    full_conn = v;
  endtask

  task automatic test_directed();
    write_connectivity(1'b0);
    send_voxel(OP_QUERY, 0, 0, 0);
    send_voxel(OP_INSERT, AXIS_MIN, AXIS_MIN, AXIS_MIN);
    send_voxel(OP_INSERT, AXIS_MAX, AXIS_MAX, AXIS_MAX);
    send_voxel(OP_INSERT, AXIS_MAX, AXIS_MAX, AXIS_MAX);
    send_voxel(OP_QUERY, AXIS_MIN, AXIS_MIN, AXIS_MIN);
    send_voxel(OP_QUERY, AXIS_MAX, AXIS_MAX, AXIS_MAX);
    send_voxel(OP_NOP, -1, -1, -1);
    // face cross around (5,5,5)
    send_voxel(OP_INSERT, 5, 5, 5);
    send_voxel(OP_INSERT, 4, 5, 5);
    send_voxel(OP_INSERT, 6, 5, 5);
    send_voxel(OP_INSERT, 5, 4, 5);
    send_voxel(OP_INSERT, 5, 6, 5);
    send_voxel(OP_INSERT, 5, 5, 4);
    send_voxel(OP_INSERT, 5, 5, 6);
    send_voxel(OP_QUERY, 5, 5, 5);
    send_voxel(OP_QUERY, 7, 5, 5);
    write_connectivity(1'b1);
    send_voxel(OP_QUERY, 5, 5, 5);
    send_voxel(OP_QUERY, AXIS_MAX, 0, AXIS_MIN);
    send_voxel(OP_CLEAR, AXIS_MAX, AXIS_MIN, 3);
    send_voxel(OP_QUERY, 5, 5, 5);
  endtask

  // fill an 8x8x8 cube, then probe its inside and its corner
  task automatic test_fill();
    int b;
    write_connectivity(1'b1);
    b = -4;
    quiet = 1'b1;
    send_voxel(OP_CLEAR, 0, 0, 0);
    for (int i = 0; i < 512; i++)
      send_voxel(OP_INSERT, b + i % 8, b + (i / 8) % 8, b + i / 64);
    quiet = 1'b0;
    send_voxel(OP_INSERT, 100, 100, 100);
    send_voxel(OP_INSERT, b, b, b);
    send_voxel(OP_QUERY, 0, 0, 0);
    send_voxel(OP_QUERY, b, b, b);
    send_voxel(OP_INSERT, AXIS_MIN, 0, AXIS_MAX);
    send_voxel(OP_CLEAR, 0, 0, 0);
    send_voxel(OP_INSERT, 100, 100, 100);
  endtask

  task automatic test_random(bit conn, int n_items);
    int bx, by, bz, r, x, y, z;
    op_t op;
    write_connectivity(conn);
    for (int i = 0; i < n_items; i++) begin
      // move the cluster now and then, sometimes against the range limits
      if (i % 100 == 0) begin
        r = $urandom_range(0, 3);
        bx = (r == 0) ? AXIS_MIN : (r == 1) ? AXIS_MAX - 3 : $urandom_range(0, 2000) - 1000;
        by = (r == 2) ? AXIS_MAX - 3 : $urandom_range(0, 2000) - 1000;
        bz = (r == 3) ? AXIS_MIN : (r == 0) ? AXIS_MAX - 3 : $urandom_range(0, 2000) - 1000;
      end
      if (i == n_items / 2) hold_receiver = 1'b1;
      r = $urandom_range(0, 99);
      op = (r < 50) ? OP_INSERT : (r < 95) ? OP_QUERY : (r < 97) ? OP_CLEAR : OP_NOP;
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end else begin
        x = bx + $urandom_range(0, 3);
        y = by + $urandom_range(0, 3);
        z = bz + $urandom_range(0, 3);
      end
      send_voxel(op, x, y, z);
    end
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    int n;
    forever begin
      if (hold_receiver) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_receiver = 1'b0;
      end
      n = quiet ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    voxel_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $error("result with no pending item: %h", out_tdata);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (got.neighbor_missing !== want.neighbor_missing) begin
          $error("neighbor_missing exp %0d got %0d", want.neighbor_missing,
                 got.neighbor_missing);
          failed = 1'b1;
        end
        if (got.self_present !== want.self_present) begin
          $error("self_present exp %0d got %0d", want.self_present, got.self_present);
          failed = 1'b1;
        end
        if (got.set_full !== want.set_full) begin
          $error("set_full exp %0d got %0d", want.set_full, got.set_full);
          failed = 1'b1;
        end
        if (got.voxel_count !== want.voxel_count) begin
          $error("voxel_count exp %0d got %0d", want.voxel_count, got.voxel_count);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item or delivered result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    occ_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1'b0, 380);
    test_fill();
    test_random(1'b1, 380);
    drain_results();
    repeat (100) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
